### hdl/prdw_pkg.sv
// Package for the pulsed roller drive: time width, op/event/register codes,
// configuration and result structs. No dependencies.
`default_nettype none

package prdw_pkg;

	localparam int TIME_BITS = 32;

	localparam int CFG_W  = 16;
	localparam int POWER_W = 8;
	localparam int TS_W   = 32;

	localparam int PDATA_W = 32;
	localparam int PADDR_W = 4;

	typedef logic [TIME_BITS-1:0] time_t;

	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_KICK = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] EVT_NONE   = 2'd0;
	localparam logic [1:0] EVT_ENGAGE = 2'd1;
	localparam logic [1:0] EVT_OFF    = 2'd2;

	localparam logic [1:0] REG_ON_TIME      = 2'd0;
	localparam logic [1:0] REG_OFF_TIME     = 2'd1;
	localparam logic [1:0] REG_FEED_TIMEOUT = 2'd2;

	localparam logic [CFG_W-1:0] ON_TIME_RST      = CFG_W'(100);
	localparam logic [CFG_W-1:0] OFF_TIME_RST     = CFG_W'(50);
	localparam logic [CFG_W-1:0] FEED_TIMEOUT_RST = CFG_W'(300);

	typedef struct packed {
		logic [CFG_W-1:0] on_time;
		logic [CFG_W-1:0] off_time;
		logic [CFG_W-1:0] feed_timeout;
	} cfg_t;

	typedef struct packed {
		logic [POWER_W-1:0] drive_level;
		logic               drive_written;
		logic [1:0]         event_code;
		logic               is_engaged;
		logic [POWER_W-1:0] held_power;
	} result_t;

endpackage

`default_nettype wire

### hdl/pulsed_roller_drive_with_watchdog.sv
// Top level of the pulsed roller drive: command input register, result
// register, APB register file. Depends on prdw_pkg, prdw_cfg, prdw_core.
//
// Usage:
//   Command channel (cmd_valid/cmd_stall, op, power_level, timestamp) carries
//   set, kick and tick items. Result channel (res_valid/res_stall) returns one
//   result per item: drive_level, drive_written, event_code, is_engaged,
//   held_power.
//   A command passes the input register, then the result register; drive
//   state updates as an item leaves the input register.
//   Throughput: one item per cycle, sustained while res_stall does not hold
//   a full result register.
//   A stalled result holds in the result register while one more command
//   waits in the input register; cmd_stall rises only when both are full.
//   Reset (arst_n low) clears both stages, disengages the motor with zero
//   drive and power, zeroes the phase and watchdog times and loads the
//   registers with on_time 100, off_time 50, feed_timeout 300.
//   Registers sit at paddr 0, 4, 8; write them only while the block is idle.
`default_nettype none

module pulsed_roller_drive_with_watchdog
	import prdw_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [1:0]         op,
	input  wire logic [POWER_W-1:0] power_level,
	input  wire logic [TS_W-1:0]    timestamp,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [POWER_W-1:0]      drive_level,
	output logic                    drive_written,
	output logic [1:0]              event_code,
	output logic                    is_engaged,
	output logic [POWER_W-1:0]      held_power,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t               cfg;
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [POWER_W-1:0] power_s1;
	time_t              now_s1;
	logic               valid_s2;
	result_t            res_s2;
	result_t            res_next;
	logic               load_s2;
	logic               load_s1;

	assign load_s2   = valid_s1 & (~valid_s2 | ~res_stall);
	assign cmd_stall = valid_s1 & ~load_s2;
	assign load_s1   = cmd_valid & ~cmd_stall;

	prdw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	prdw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load_s2),
		.op     (op_s1),
		.power  (power_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (~res_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1    <= op;
			power_s1 <= power_level;
			now_s1   <= TIME_BITS'(timestamp);
		end
		if (load_s2) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid     = valid_s2;
	assign drive_level   = res_s2.drive_level;
	assign drive_written = res_s2.drive_written;
	assign event_code    = res_s2.event_code;
	assign is_engaged    = res_s2.is_engaged;
	assign held_power    = res_s2.held_power;

endmodule

`default_nettype wire

### hdl/prdw_cfg.sv
// APB register file for on_time, off_time and feed_timeout.
// Depends on prdw_pkg.
`default_nettype none

module prdw_cfg
	import prdw_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_time      <= ON_TIME_RST;
			cfg_q.off_time     <= OFF_TIME_RST;
			cfg_q.feed_timeout <= FEED_TIMEOUT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ON_TIME:      cfg_q.on_time      <= pwdata[CFG_W-1:0];
				REG_OFF_TIME:     cfg_q.off_time     <= pwdata[CFG_W-1:0];
				REG_FEED_TIMEOUT: cfg_q.feed_timeout <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ON_TIME:      prdata = PDATA_W'(cfg_q.on_time);
			REG_OFF_TIME:     prdata = PDATA_W'(cfg_q.off_time);
			REG_FEED_TIMEOUT: prdata = PDATA_W'(cfg_q.feed_timeout);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hdl/prdw_core.sv
// Drive state (engage flag, power, phase, watchdog time) and the per-item
// next-state logic. Depends on prdw_pkg.
`default_nettype none

module prdw_core
	import prdw_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [1:0]         op,
	input  wire logic [POWER_W-1:0] power,
	input  wire time_t              now,
	input  wire cfg_t               cfg,
	output result_t                 res
);

	logic               eng_q,   eng_d;
	logic [POWER_W-1:0] pow_q,   pow_d;
	logic               ph_on_q, ph_on_d;
	time_t              ph_start_q, ph_start_d;
	time_t              feed_q,  feed_d;
	logic [POWER_W-1:0] drv_q,   drv_d;
	logic               written;
	logic [1:0]         evt;
	time_t              since_feed, since_phase;

	// modulo 2^TIME_BITS differences
	assign since_feed  = now - feed_q;
	assign since_phase = now - ph_start_q;

	always_comb begin
		eng_d      = eng_q;
		pow_d      = pow_q;
		ph_on_d    = ph_on_q;
		ph_start_d = ph_start_q;
		feed_d     = feed_q;
		drv_d      = drv_q;
		written    = 1'b0;
		evt        = EVT_NONE;
		case (op)
			OP_SET: begin
				if (power == '0) begin
					evt     = eng_q ? EVT_OFF : EVT_NONE;
					eng_d   = 1'b0;
					pow_d   = '0;
					drv_d   = '0;
					written = 1'b1;
				end else begin
					if (!eng_q) begin
						eng_d      = 1'b1;
						ph_on_d    = 1'b1;
						ph_start_d = now;
						drv_d      = power;
						written    = 1'b1;
						evt        = EVT_ENGAGE;
					end else if (ph_on_q && power != pow_q) begin
						drv_d   = power;
						written = 1'b1;
					end
					pow_d  = power;
					feed_d = now;
				end
			end
			OP_KICK: begin
				eng_d   = 1'b0;
				pow_d   = '0;
				drv_d   = '0;
				written = 1'b1;
			end
			OP_TICK: begin
				if (eng_q) begin
					if (since_feed >= TIME_BITS'(cfg.feed_timeout)) begin
						evt     = EVT_OFF;
						eng_d   = 1'b0;
						pow_d   = '0;
						drv_d   = '0;
						written = 1'b1;
					end else if (ph_on_q) begin
						if (since_phase >= TIME_BITS'(cfg.on_time)) begin
							ph_on_d    = 1'b0;
							ph_start_d = now;
							drv_d      = '0;
							written    = 1'b1;
						end
					end else if (since_phase >= TIME_BITS'(cfg.off_time)) begin
						ph_on_d    = 1'b1;
						ph_start_d = now;
						drv_d      = pow_q;
						written    = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q      <= 1'b0;
			pow_q      <= '0;
			ph_on_q    <= 1'b0;
			ph_start_q <= '0;
			feed_q     <= '0;
			drv_q      <= '0;
		end else if (step) begin
			eng_q      <= eng_d;
			pow_q      <= pow_d;
			ph_on_q    <= ph_on_d;
			ph_start_q <= ph_start_d;
			feed_q     <= feed_d;
			drv_q      <= drv_d;
		end
	end

	assign res.drive_level   = drv_d;
	assign res.drive_written = written;
	assign res.event_code    = evt;
	assign res.is_engaged    = eng_d;
	assign res.held_power    = pow_d;

endmodule

`default_nettype wire

### hdl/prdw_checker.sv
// Port-level checker for the pulsed roller drive, bound to the top level.
// Depends on prdw_pkg.
`default_nettype none

module prdw_checker
	import prdw_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic [POWER_W-1:0] drive_level,
	input wire logic               drive_written,
	input wire logic [1:0]         event_code,
	input wire logic               is_engaged,
	input wire logic [POWER_W-1:0] held_power
);

	// an engage event always writes the drive and leaves the motor engaged
	a_engage: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_code == EVT_ENGAGE |-> is_engaged && drive_written)
		else $error("engage event without engaged drive write");

	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_code == EVT_OFF |->
			!is_engaged && drive_written && drive_level == '0 && held_power == '0)
		else $error("off event left drive or power set");

	// a disengaged motor never drives and holds no power
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_engaged |-> drive_level == '0 && held_power == '0)
		else $error("drive or power nonzero while disengaged");

	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> event_code == EVT_NONE || event_code == EVT_ENGAGE ||
			event_code == EVT_OFF)
		else $error("undefined event code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(drive_level) &&
			$stable(event_code) && $stable(held_power))
		else $error("stalled result changed");

endmodule

bind pulsed_roller_drive_with_watchdog prdw_checker u_prdw_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking bench for pulsed_roller_drive_with_watchdog: directed and random
// command transfers, in-bench prediction of drive reports, APB timing setup.
// Depends on prdw_pkg and the block's RTL only.
module tb
	import prdw_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int RUN_LIMIT = 400_000;
	localparam int LONG_HOLD = 150;

	typedef struct {
		logic [1:0]         op;
		logic [POWER_W-1:0] power;
		logic [TS_W-1:0]    ts;
	} cmd_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	logic [1:0]           op = OP_TICK;
	logic [POWER_W-1:0]   power_level = '0;
	logic [TS_W-1:0]      timestamp = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [POWER_W-1:0]   drive_level;
	logic                 drive_written;
	logic [1:0]           event_code;
	logic                 is_engaged;
	logic [POWER_W-1:0]   held_power;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	pulsed_roller_drive_with_watchdog i_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.op(op), .power_level(power_level), .timestamp(timestamp),
		.res_valid(res_valid), .res_stall(res_stall),
		.drive_level(drive_level), .drive_written(drive_written),
		.event_code(event_code), .is_engaged(is_engaged), .held_power(held_power),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// predicted drive state and timing registers
	logic [CFG_W-1:0]   t_on = ON_TIME_RST;
	logic [CFG_W-1:0]   t_off = OFF_TIME_RST;
	logic [CFG_W-1:0]   t_wdt = FEED_TIMEOUT_RST;
	logic               run_on = 1'b0;
	logic [POWER_W-1:0] hold_pw = '0;
	logic               in_on_phase = 1'b0;
	time_t              phase_mark = '0;
	time_t              feed_mark = '0;
	logic [POWER_W-1:0] motor_lvl = '0;

	cmd_t    cmd_queue[$];
	result_t pending_reports[$];
	int      bad_results = 0;
	logic    cmd_moved = 1'b0;
	logic    calm = 1'b0;
	int      long_hold_asked = 0;
	logic [TS_W-1:0]    now_ms = '0;
	logic [POWER_W-1:0] last_pw = 8'd1;
	int unsigned cycle_count = 0;

	function automatic result_t roller_update(input cmd_t c);
		result_t r;
		time_t now;
		now = time_t'(c.ts);
		r.drive_written = 1'b0;
		r.event_code = EVT_NONE;
		case (c.op)
			OP_SET: begin
				if (c.power == '0) begin
					if (run_on)
						r.event_code = EVT_OFF;
					run_on = 1'b0;
					hold_pw = '0;
					motor_lvl = '0;
					r.drive_written = 1'b1;
				end else begin
					if (!run_on) begin
						run_on = 1'b1;
						in_on_phase = 1'b1;
						phase_mark = now;
						motor_lvl = c.power;
						r.drive_written = 1'b1;
						r.event_code = EVT_ENGAGE;
					end else if (in_on_phase && c.power != hold_pw) begin
						motor_lvl = c.power;
						r.drive_written = 1'b1;
					end
					hold_pw = c.power;
					feed_mark = now;
				end
			end
			OP_KICK: begin
				run_on = 1'b0;
				hold_pw = '0;
				motor_lvl = '0;
				r.drive_written = 1'b1;
			end
			OP_TICK: begin
				if (run_on) begin
					if (time_t'(now - feed_mark) >= time_t'(t_wdt)) begin
						r.event_code = EVT_OFF;
						run_on = 1'b0;
						hold_pw = '0;
						motor_lvl = '0;
						r.drive_written = 1'b1;
					end else if (in_on_phase) begin
						if (time_t'(now - phase_mark) >= time_t'(t_on)) begin
							in_on_phase = 1'b0;
							phase_mark = now;
							motor_lvl = '0;
							r.drive_written = 1'b1;
						end
					end else if (time_t'(now - phase_mark) >= time_t'(t_off)) begin
						in_on_phase = 1'b1;
						phase_mark = now;
						motor_lvl = hold_pw;
						r.drive_written = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.drive_level = motor_lvl;
		r.is_engaged = run_on;
		r.held_power = hold_pw;
		return r;
	endfunction

	// result checking and prediction of each accepted command
	always @(posedge clk) begin : check_side
		result_t got;
		result_t want;
		cmd_t c;
		cmd_moved = arst_n && cmd_valid && !cmd_stall;
		if (arst_n && res_valid && !res_stall) begin
			got.drive_level = drive_level;
			got.drive_written = drive_written;
			got.event_code = event_code;
			got.is_engaged = is_engaged;
			got.held_power = held_power;
			if (pending_reports.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("%0t: result with nothing expected: drive %0d wr %0b evt %0d eng %0b pwr %0d",
						$realtime, got.drive_level, got.drive_written, got.event_code,
						got.is_engaged, got.held_power);
			end else begin
				want = pending_reports.pop_front();
				if (got.drive_level !== want.drive_level
						|| got.drive_written !== want.drive_written
						|| got.event_code !== want.event_code
						|| got.is_engaged !== want.is_engaged
						|| got.held_power !== want.held_power) begin
					bad_results++;
					if (bad_results <= 10)
						$display("%0t: mismatch exp drive %0d wr %0b evt %0d eng %0b pwr %0d / got %0d %0b %0d %0b %0d",
							$realtime, want.drive_level, want.drive_written, want.event_code,
							want.is_engaged, want.held_power, got.drive_level,
							got.drive_written, got.event_code, got.is_engaged, got.held_power);
				end
			end
		end
		if (cmd_moved) begin
			c.op = op;
			c.power = power_level;
			c.ts = timestamp;
			pending_reports.push_back(roller_update(c));
		end
	end

	// command driver: advances only after a transfer or while idle
	always @(negedge clk) begin : cmd_driver
		int send_wait;
		cmd_t nxt;
		if (arst_n && (!cmd_valid || cmd_moved)) begin
			if (send_wait > 0) begin
				send_wait--;
				cmd_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				send_wait = $urandom_range(1, 17) - 1;
				cmd_valid <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				nxt = cmd_queue.pop_front();
				cmd_valid <= 1'b1;
				op <= nxt.op;
				power_level <= nxt.power;
				timestamp <= nxt.ts;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result receiver stall bursts, plus long hold-offs on request
	always @(negedge clk) begin : res_receiver
		int hold_left;
		int long_done;
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (long_hold_asked > long_done) begin
			long_done++;
			hold_left = LONG_HOLD - 1;
			res_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(1, 17) - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [1:0] opc, input logic [POWER_W-1:0] pw,
			input logic [TS_W-1:0] ts);
		cmd_t c;
		c.op = opc;
		c.power = pw;
		c.ts = ts;
		cmd_queue.push_back(c);
	endtask

	task automatic wait_idle();
		while (cmd_queue.size() != 0 || cmd_valid || pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ON_TIME:      t_on = value;
			REG_OFF_TIME:     t_off = value;
			REG_FEED_TIMEOUT: t_wdt = value;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_timing(input logic [CFG_W-1:0] on_v, input logic [CFG_W-1:0] off_v,
			input logic [CFG_W-1:0] wdt_v);
		apb_write(REG_ON_TIME, on_v);
		apb_write(REG_OFF_TIME, off_v);
		apb_write(REG_FEED_TIMEOUT, wdt_v);
	endtask

	// mostly coherent engage/feed/tick traffic on a running clock, some noise
	task automatic queue_traffic(input int count);
		int pick;
		int span;
		logic [POWER_W-1:0] pw;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 3))
				0: span = t_on / 2;
				1: span = t_off / 2;
				2: span = t_wdt / 4;
				default: span = t_wdt + 2;
			endcase
			now_ms += TS_W'($urandom_range(0, span + 1));
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				queue_cmd(2'($urandom_range(0, 3)), POWER_W'($urandom), TS_W'($urandom));
			end else if (pick < 30) begin
				if ($urandom_range(0, 2) != 0)
					last_pw = POWER_W'($urandom_range(1, 255));
				pw = last_pw;
				queue_cmd(OP_SET, pw, now_ms);
			end else if (pick < 33) begin
				queue_cmd(OP_SET, '0, now_ms);
			end else if (pick < 35) begin
				queue_cmd(OP_KICK, POWER_W'($urandom), now_ms);
			end else begin
				queue_cmd(OP_TICK, POWER_W'($urandom), now_ms);
			end
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// reset timing: 100 on, 50 off, 300 watchdog
		queue_cmd(OP_TICK, 8'd0, 32'd0);                // tick while disengaged
		queue_cmd(OP_SPARE, 8'hFF, 32'hFFFF_FFFF);      // unused op code
		queue_cmd(OP_SET, 8'd0, 32'd5);                 // zero set, disengaged
		queue_cmd(OP_KICK, 8'd0, 32'd0);
		queue_cmd(OP_SET, 8'hFF, 32'd1000);             // engage
		queue_cmd(OP_SET, 8'hFF, 32'd1010);             // same power, no rewrite
		queue_cmd(OP_SET, 8'd1, 32'd1020);
		queue_cmd(OP_TICK, 8'd0, 32'd1099);
		queue_cmd(OP_TICK, 8'd0, 32'd1100);             // to off phase
		queue_cmd(OP_SET, 8'd200, 32'd1110);            // stored, not driven
		queue_cmd(OP_TICK, 8'd0, 32'd1149);
		queue_cmd(OP_TICK, 8'd0, 32'd1150);             // back on at 200
		queue_cmd(OP_SPARE, 8'd0, 32'd0);
		queue_cmd(OP_TICK, 8'd0, 32'd1409);
		queue_cmd(OP_TICK, 8'd0, 32'd1410);             // watchdog at exactly the limit
		queue_cmd(OP_SET, 8'd77, 32'hFFFF_FFF0);
		queue_cmd(OP_TICK, 8'd0, 32'h0000_0100);        // elapsed across the wrap
		queue_cmd(OP_SET, 8'h80, 32'h0000_0120);
		queue_cmd(OP_KICK, 8'hAA, 32'h0000_0130);       // kick cut while engaged
		queue_cmd(OP_SET, 8'h55, 32'h5555_5555);
		queue_cmd(OP_SET, 8'd0, 32'hAAAA_AAAA);         // zero set while engaged
		wait_idle();

		set_timing('0, '0, '0);
		queue_cmd(OP_SET, 8'd9, 32'd7);
		queue_cmd(OP_TICK, 8'd0, 32'd7);                // zero watchdog trips at once
		now_ms = TS_W'($urandom);
		queue_traffic(120);
		wait_idle();

		set_timing('1, '1, '1);
		now_ms = 32'hFFF0_0000;
		queue_traffic(140);
		long_hold_asked++;
		wait_idle();

		set_timing(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 40)),
			CFG_W'($urandom_range(60, 200)));
		queue_traffic(70);
		long_hold_asked++;
		queue_traffic(70);
		wait_idle();

		set_timing(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
		queue_traffic(100);
		wait_idle();

		set_timing(ON_TIME_RST, OFF_TIME_RST, FEED_TIMEOUT_RST);
		calm = 1'b1;
		queue_traffic(150);
		wait_idle();

		repeat (8) @(posedge clk);
		if (bad_results == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/prdw_pkg.sv
hdl/prdw_cfg.sv
hdl/prdw_core.sv
hdl/pulsed_roller_drive_with_watchdog.sv
hdl/prdw_checker.sv
tb/sv/tb.sv
